FILE: rtl/sbc_pkg.sv
// Shared types and constants for the swept box collision block.
// Holds the port payload structs, the internal front-to-back job and stage
// records, fixed-point widths and axis codes. No dependencies.
package sbc_pkg;

  // Fixed point: fraction bits of all Q formats
  localparam int FRAC_BITS = 16;
  localparam int FT_W      = FRAC_BITS + 8;   // frame time, Q8.F
  localparam int RATIO_W   = FRAC_BITS + 1;   // hit ratio, Q1.F in [0, 1]
  localparam int Q_W       = FRAC_BITS + 3;   // signed ratio in [-2, +2]
  localparam int DIST_W    = 35;              // doubled signed distance
  localparam int MAG_W     = 34;              // magnitude of a doubled distance
  localparam int RV_W      = 33;              // signed relative velocity
  localparam int DEN_W     = RV_W + FT_W;     // |rv| * frame_time
  localparam int DIV_LAT   = FRAC_BITS + 4;   // divider pipeline depth

  localparam logic [FT_W-1:0]    FT_RESET = FT_W'(1092);
  localparam logic [Q_W-1:0]     RLIM_Q   = Q_W'(1) << (FRAC_BITS + 1);
  localparam logic [RATIO_W-1:0] ONE_Q    = RATIO_W'(1) << FRAC_BITS;

  // Hit axis codes
  localparam logic [1:0] AXIS_NONE = 2'd0;
  localparam logic [1:0] AXIS_X    = 2'd1;
  localparam logic [1:0] AXIS_Y    = 2'd2;

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic        [30:0] target_w;
    logic        [30:0] target_h;
    logic signed [31:0] target_vx;
    logic signed [31:0] target_vy;
    logic signed [31:0] other_x;
    logic signed [31:0] other_y;
    logic        [30:0] other_w;
    logic        [30:0] other_h;
    logic signed [31:0] other_vx;
    logic signed [31:0] other_vy;
  } sbc_in_t;

  typedef struct packed {
    logic                hit;
    logic [1:0]          hit_axis;
    logic signed [31:0]  push_value;
    logic [RATIO_W-1:0]  hit_ratio;
    logic [FT_W-1:0]     time_left;
    logic signed [31:0]  contact_x;
    logic signed [31:0]  contact_y;
  } sbc_out_t;

  // Front register: relative velocities and doubled entry/exit distances
  typedef struct packed {
    logic signed [31:0]       tx;
    logic signed [31:0]       ty;
    logic signed [31:0]       tvx;
    logic signed [31:0]       tvy;
    logic signed [RV_W-1:0]   rvx;
    logic signed [RV_W-1:0]   rvy;
    logic signed [DIST_W-1:0] dex;
    logic signed [DIST_W-1:0] dxx;
    logic signed [DIST_W-1:0] dey;
    logic signed [DIST_W-1:0] dxy;
  } sbc_pre_t;

  // Per-axis divider operands and classification
  typedef struct packed {
    logic [MAG_W-1:0] ent_mag;
    logic [MAG_W-1:0] ext_mag;
    logic             ent_neg;
    logic             ext_neg;
    logic [DEN_W-1:0] den;
    logic             idle;       // no relative motion or zero frame time
    logic             dent_zero;
    logic             dent_neg;
  } sbc_axis_t;

  typedef struct packed {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tvx;
    logic signed [31:0] tvy;
    sbc_axis_t          ax;
    sbc_axis_t          ay;
  } sbc_job_t;

  // Data that rides alongside the dividers
  typedef struct packed {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tvx;
    logic signed [31:0] tvy;
    logic               x_idle;
    logic               y_idle;
    logic               x_dz;
    logic               x_dn;
    logic               y_dz;
    logic               y_dn;
  } sbc_side_t;

  // Resolved hit decision
  typedef struct packed {
    logic               miss;
    logic               on_x;
    logic signed [31:0] push;
    logic [RATIO_W-1:0] ren;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tvx;
    logic signed [31:0] tvy;
  } sbc_res_t;

endpackage

FILE: rtl/sbc_fifo.sv
// Small register queue with a typed payload, used between the front and back
// and in front of the result port. Depends on nothing.
module sbc_fifo #(
  parameter int  DEPTH = 2,
  parameter type T     = logic
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  T     wdata,
  input  logic rd,
  output T     rdata,
  output logic full,
  output logic empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  T                 mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Advance pointers with wrap at DEPTH
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (wr) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (rd) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (wr && !rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store the request payload
  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rptr_r];
  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);

endmodule

FILE: rtl/sbc_front.sv
// Front end: takes a request, forms relative velocities and doubled entry and
// exit distances, then magnitudes, signs and divisors for the back end.
// Depends on sbc_pkg.
module sbc_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  sbc_pkg::sbc_in_t             in_data,
  input  logic [sbc_pkg::FT_W-1:0]     frame_time,
  output logic                         job_valid,
  input  logic                         job_ready,
  output sbc_pkg::sbc_job_t            job
);

  localparam int RV_W   = sbc_pkg::RV_W;
  localparam int DIST_W = sbc_pkg::DIST_W;
  localparam int MAG_W  = sbc_pkg::MAG_W;
  localparam int DEN_W  = sbc_pkg::DEN_W;
  localparam int FT_W   = sbc_pkg::FT_W;

  sbc_pkg::sbc_pre_t pre_r, pre_nxt;
  logic              v_r;
  logic              take;

  // Signed distances on one axis, doubled so half sizes stay exact
  function automatic void axis_dist(
    input  logic signed [31:0]       tp,
    input  logic        [30:0]       ts,
    input  logic signed [31:0]       op,
    input  logic        [30:0]       os,
    input  logic signed [RV_W-1:0]   rv,
    output logic signed [DIST_W-1:0] de,
    output logic signed [DIST_W-1:0] dx
  );
    logic signed [DIST_W-1:0] gap;
    logic signed [DIST_W-1:0] sz;
    gap = (DIST_W'(op) - DIST_W'(tp)) <<< 1;
    sz  = DIST_W'(ts) + DIST_W'(os);
    if (!rv[RV_W-1] && (rv != '0)) begin
      de = gap - sz;
      dx = gap + sz;
    end else begin
      de = gap + sz;
      dx = gap - sz;
    end
  endfunction

  // Divider operands for one axis
  function automatic sbc_pkg::sbc_axis_t make_axis(
    input logic signed [RV_W-1:0]   rv,
    input logic signed [DIST_W-1:0] de,
    input logic signed [DIST_W-1:0] dx,
    input logic [FT_W-1:0]          t
  );
    sbc_pkg::sbc_axis_t a;
    logic [RV_W-1:0]    rv_mag;
    rv_mag      = rv[RV_W-1] ? RV_W'(-rv) : RV_W'(rv);
    a.den       = DEN_W'(rv_mag) * DEN_W'(t);
    a.ent_mag   = de[DIST_W-1] ? MAG_W'(-de) : MAG_W'(de);
    a.ext_mag   = dx[DIST_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
    a.ent_neg   = (de != '0) && (de[DIST_W-1] != rv[RV_W-1]);
    a.ext_neg   = (dx != '0) && (dx[DIST_W-1] != rv[RV_W-1]);
    a.idle      = (rv == '0) || (t == '0);
    a.dent_zero = (de == '0);
    a.dent_neg  = de[DIST_W-1];
    return a;
  endfunction

  // Form distances from the incoming request
  always_comb begin
    pre_nxt.tx  = in_data.target_x;
    pre_nxt.ty  = in_data.target_y;
    pre_nxt.tvx = in_data.target_vx;
    pre_nxt.tvy = in_data.target_vy;
    pre_nxt.rvx = RV_W'(in_data.target_vx) - RV_W'(in_data.other_vx);
    pre_nxt.rvy = RV_W'(in_data.target_vy) - RV_W'(in_data.other_vy);
    axis_dist(in_data.target_x, in_data.target_w, in_data.other_x, in_data.other_w,
              pre_nxt.rvx, pre_nxt.dex, pre_nxt.dxx);
    axis_dist(in_data.target_y, in_data.target_h, in_data.other_y, in_data.other_h,
              pre_nxt.rvy, pre_nxt.dey, pre_nxt.dxy);
  end

  // Hold the stage while the queue is full
  assign full = v_r && !job_ready;
  assign take = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (take) begin
      v_r <= 1'b1;
    end else if (job_ready) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pre_r <= pre_nxt;
    end
  end

  // Classify and build divisors
  always_comb begin
    job.tx  = pre_r.tx;
    job.ty  = pre_r.ty;
    job.tvx = pre_r.tvx;
    job.tvy = pre_r.tvy;
    job.ax  = make_axis(pre_r.rvx, pre_r.dex, pre_r.dxx, frame_time);
    job.ay  = make_axis(pre_r.rvy, pre_r.dey, pre_r.dxy, frame_time);
  end

  assign job_valid = v_r;

endmodule

FILE: rtl/sbc_div.sv
// Pipelined restoring divider giving a floor ratio in signed Q2.F clamped to [-2, +2].
// One quotient bit per stage, enable-gated with the back end.
// Depends on sbc_pkg.
module sbc_div (
  input  logic                              clk,
  input  logic                              en,
  input  logic [sbc_pkg::MAG_W-1:0]         num_mag,
  input  logic [sbc_pkg::DEN_W-1:0]         den,
  input  logic                              neg,
  output logic signed [sbc_pkg::Q_W-1:0]    q
);

  localparam int FB    = sbc_pkg::FRAC_BITS;
  localparam int MAG_W = sbc_pkg::MAG_W;
  localparam int DEN_W = sbc_pkg::DEN_W;
  localparam int Q_W   = sbc_pkg::Q_W;
  localparam int SH    = 2 * FB - 1;
  localparam int QB    = FB + 2;
  localparam int RW    = DEN_W + QB;
  localparam int NW    = MAG_W + SH;
  localparam int CW    = (NW > RW) ? NW : RW;
  localparam logic [QB-1:0] RLIM = QB'(sbc_pkg::RLIM_Q);

  logic [RW-1:0]    rem_r [QB+1];
  logic [QB-1:0]    quo_r [QB+1];
  logic [DEN_W-1:0] den_r [QB+1];
  logic             neg_r [QB+1];
  logic             ovf_r [QB+1];

  logic [CW-1:0] n_ext;
  logic [CW-1:0] d_ext;
  logic [RW-1:0] trial [QB+1];
  logic          fit   [QB+1];
  logic [QB-1:0] q_sat;
  logic [QB-1:0] q_mag;
  logic signed [Q_W-1:0] q_s;

  assign n_ext = CW'(num_mag) << SH;
  assign d_ext = CW'(den) << QB;

  // Trial subtrahend of each step
  always_comb begin
    trial[0] = '0;
    fit[0]   = 1'b0;
    for (int k = 1; k <= QB; k++) begin
      trial[k] = RW'(den_r[k-1]) << (QB - k);
      fit[k]   = rem_r[k-1] >= trial[k];
    end
  end

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= RW'(n_ext);
      quo_r[0] <= '0;
      den_r[0] <= den;
      neg_r[0] <= neg;
      ovf_r[0] <= n_ext >= d_ext;
      for (int k = 1; k <= QB; k++) begin
        rem_r[k] <= fit[k] ? rem_r[k-1] - trial[k] : rem_r[k-1];
        quo_r[k] <= fit[k] ? quo_r[k-1] | (QB'(1) << (QB - k)) : quo_r[k-1];
        den_r[k] <= den_r[k-1];
        neg_r[k] <= neg_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  // Round negatives toward minus infinity and clamp
  always_comb begin
    if (ovf_r[QB] || (quo_r[QB] > RLIM)) begin
      q_sat = RLIM;
    end else begin
      q_sat = quo_r[QB] + QB'(neg_r[QB] && (rem_r[QB] != '0));
    end
    q_mag = (q_sat > RLIM) ? RLIM : q_sat;
    q_s   = Q_W'(q_mag);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= neg_r[QB] ? -q_s : q_s;
    end
  end

endmodule

FILE: rtl/sbc_back.sv
// Back end: four ratio dividers, hit decision, contact time and position.
// Stalls as one pipeline on the result queue. Depends on sbc_pkg, sbc_div.
module sbc_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [sbc_pkg::FT_W-1:0] frame_time,
  input  logic                     job_valid,
  input  sbc_pkg::sbc_job_t        job,
  output logic                     job_pop,
  output logic                     res_valid,
  input  logic                     res_ready,
  output sbc_pkg::sbc_out_t        res
);

  localparam int FB      = sbc_pkg::FRAC_BITS;
  localparam int Q_W     = sbc_pkg::Q_W;
  localparam int FT_W    = sbc_pkg::FT_W;
  localparam int RATIO_W = sbc_pkg::RATIO_W;
  localparam int LAT     = sbc_pkg::DIV_LAT;
  localparam int PW      = FT_W + 33;
  localparam int SW      = PW + 1;
  localparam logic signed [Q_W-1:0] RLIM_S = sbc_pkg::RLIM_Q;
  localparam logic signed [Q_W-1:0] ONE_S  = Q_W'(sbc_pkg::ONE_Q);

  logic adv;

  sbc_pkg::sbc_side_t side_r [LAT];
  logic               sv_r   [LAT];

  logic signed [Q_W-1:0] q_xe, q_xx, q_ye, q_yx;

  sbc_pkg::sbc_res_t r1_nxt, r1_r, r2_r, r3_r;
  logic              r1_v_r, r2_v_r, r3_v_r;
  logic [FT_W-1:0]   dt_r, tl_r;
  logic signed [PW-1:0] px_r, py_r;

  // Whole back end moves unless a finished result is blocked
  assign adv     = !r3_v_r || res_ready;
  assign job_pop = adv && job_valid;

  sbc_div u_div_xe (.clk(clk), .en(adv), .num_mag(job.ax.ent_mag), .den(job.ax.den),
                    .neg(job.ax.ent_neg), .q(q_xe));
  sbc_div u_div_xx (.clk(clk), .en(adv), .num_mag(job.ax.ext_mag), .den(job.ax.den),
                    .neg(job.ax.ext_neg), .q(q_xx));
  sbc_div u_div_ye (.clk(clk), .en(adv), .num_mag(job.ay.ent_mag), .den(job.ay.den),
                    .neg(job.ay.ent_neg), .q(q_ye));
  sbc_div u_div_yx (.clk(clk), .en(adv), .num_mag(job.ay.ext_mag), .den(job.ay.den),
                    .neg(job.ay.ext_neg), .q(q_yx));

  // Carry side data and valid bits alongside the dividers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) begin
        sv_r[k] <= 1'b0;
      end
      r1_v_r <= 1'b0;
      r2_v_r <= 1'b0;
      r3_v_r <= 1'b0;
    end else if (adv) begin
      sv_r[0] <= job_pop;
      for (int k = 1; k < LAT; k++) begin
        sv_r[k] <= sv_r[k-1];
      end
      r1_v_r <= sv_r[LAT-1];
      r2_v_r <= r1_v_r;
      r3_v_r <= r2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0].tx     <= job.tx;
      side_r[0].ty     <= job.ty;
      side_r[0].tvx    <= job.tvx;
      side_r[0].tvy    <= job.tvy;
      side_r[0].x_idle <= job.ax.idle;
      side_r[0].y_idle <= job.ay.idle;
      side_r[0].x_dz   <= job.ax.dent_zero;
      side_r[0].x_dn   <= job.ax.dent_neg;
      side_r[0].y_dz   <= job.ay.dent_zero;
      side_r[0].y_dn   <= job.ay.dent_neg;
      for (int k = 1; k < LAT; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Decide hit or miss, pick the axis and the push value
  always_comb begin
    logic signed [Q_W-1:0] xe, xx, ye, yx, ren, rex;
    logic signed [32:0]    v, vm, pv;
    logic                  dz, dn;
    xe  = side_r[LAT-1].x_idle ? -RLIM_S : q_xe;
    xx  = side_r[LAT-1].x_idle ?  RLIM_S : q_xx;
    ye  = side_r[LAT-1].y_idle ? -RLIM_S : q_ye;
    yx  = side_r[LAT-1].y_idle ?  RLIM_S : q_yx;
    ren = (xe > ye) ? xe : ye;
    rex = (xx < yx) ? xx : yx;
    r1_nxt.miss = (ren > rex) || (xe[Q_W-1] && ye[Q_W-1]) || (xe > ONE_S) || (ye > ONE_S);
    r1_nxt.on_x = xe > ye;
    v  = r1_nxt.on_x ? 33'(side_r[LAT-1].tvx) : 33'(side_r[LAT-1].tvy);
    dz = r1_nxt.on_x ? side_r[LAT-1].x_dz : side_r[LAT-1].y_dz;
    dn = r1_nxt.on_x ? side_r[LAT-1].x_dn : side_r[LAT-1].y_dn;
    vm = v[32] ? -v : v;
    if (dz) begin
      pv = -v;
    end else if (dn) begin
      pv = vm;
    end else begin
      pv = -vm;
    end
    r1_nxt.push = (pv > 33'sd2147483647) ? 32'sh7fffffff : pv[31:0];
    r1_nxt.ren  = RATIO_W'(ren);
    r1_nxt.tx   = side_r[LAT-1].tx;
    r1_nxt.ty   = side_r[LAT-1].ty;
    r1_nxt.tvx  = side_r[LAT-1].tvx;
    r1_nxt.tvy  = side_r[LAT-1].tvy;
  end

  // Stage 1 hold, stage 2 contact time, stage 3 displacement products
  always_ff @(posedge clk) begin
    logic [RATIO_W+FT_W-1:0] tprod;
    logic signed [FT_W:0]    dt_s;
    if (adv) begin
      r1_r  <= r1_nxt;
      tprod = (RATIO_W + FT_W)'(r1_r.ren) * (RATIO_W + FT_W)'(frame_time);
      dt_r  <= FT_W'(tprod >> FB);
      r2_r  <= r1_r;
      dt_s  = {1'b0, dt_r};
      px_r  <= PW'(dt_s) * PW'(r2_r.tvx);
      py_r  <= PW'(dt_s) * PW'(r2_r.tvy);
      tl_r  <= frame_time - dt_r;
      r3_r  <= r2_r;
    end
  end

  // Final contact sums and result fields
  always_comb begin
    logic signed [SW-1:0] cx, cy;
    cx = SW'(r3_r.tx) + SW'(px_r >>> FB);
    cy = SW'(r3_r.ty) + SW'(py_r >>> FB);
    if (r3_r.miss) begin
      res.hit        = 1'b0;
      res.hit_axis   = sbc_pkg::AXIS_NONE;
      res.push_value = '0;
      res.hit_ratio  = sbc_pkg::ONE_Q;
      res.time_left  = '1;
      res.contact_x  = '0;
      res.contact_y  = '0;
    end else begin
      res.hit        = 1'b1;
      res.hit_axis   = r3_r.on_x ? sbc_pkg::AXIS_X : sbc_pkg::AXIS_Y;
      res.push_value = r3_r.push;
      res.hit_ratio  = r3_r.ren;
      res.time_left  = tl_r;
      if (cx > SW'(33'sd2147483647)) begin
        res.contact_x = 32'sh7fffffff;
      end else if (cx < -SW'(33'sd2147483648)) begin
        res.contact_x = 32'sh80000000;
      end else begin
        res.contact_x = cx[31:0];
      end
      if (cy > SW'(33'sd2147483647)) begin
        res.contact_y = 32'sh7fffffff;
      end else if (cy < -SW'(33'sd2147483648)) begin
        res.contact_y = 32'sh80000000;
      end else begin
        res.contact_y = cy[31:0];
      end
    end
  end

  assign res_valid = r3_v_r && res_ready;

endmodule

FILE: rtl/swept_box_collision.sv
// Swept collision test of two axis-aligned boxes over one frame, Q16.16.
// Throughput: one request per cycle while results drain; a full result queue
// that is not popped stalls the back end. The four pipelined ratio dividers give
// one quotient bit per stage over FRAC_BITS+2 stages.
// Reset (rst_n low, synchronous): queues and pipeline empty, frame_time 1092.
// Depends on sbc_pkg, sbc_fifo, sbc_front, sbc_div, sbc_back.
module swept_box_collision #(
  parameter int MQ_DEPTH = 2,
  parameter int OQ_DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  output logic                     full,
  input  sbc_pkg::sbc_in_t         in_data,
  output logic                     empty,
  input  logic                     pop,
  output sbc_pkg::sbc_out_t        out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [sbc_pkg::FT_W-1:0] cfg_data
);

  logic [sbc_pkg::FT_W-1:0] frame_time_r;

  logic              job_valid, job_pop, mq_full, mq_empty;
  sbc_pkg::sbc_job_t job_in, job_out;
  logic              res_valid, res_ready, oq_full, oq_rd;
  sbc_pkg::sbc_out_t res;

  // Frame time register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_time_r <= sbc_pkg::FT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frame_time_r <= cfg_data;
    end
  end

  sbc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_data    (in_data),
    .frame_time (frame_time_r),
    .job_valid  (job_valid),
    .job_ready  (!mq_full),
    .job        (job_in)
  );

  sbc_fifo #(.DEPTH(MQ_DEPTH), .T(sbc_pkg::sbc_job_t)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (job_valid && !mq_full),
    .wdata (job_in),
    .rd    (job_pop),
    .rdata (job_out),
    .full  (mq_full),
    .empty (mq_empty)
  );

  sbc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .frame_time (frame_time_r),
    .job_valid  (!mq_empty),
    .job        (job_out),
    .job_pop    (job_pop),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // Result queue; a pop frees a slot in the same cycle
  assign oq_rd     = pop && !empty;
  assign res_ready = !oq_full || oq_rd;

  sbc_fifo #(.DEPTH(OQ_DEPTH), .T(sbc_pkg::sbc_out_t)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (res_valid),
    .wdata (res),
    .rd    (oq_rd),
    .rdata (out_data),
    .full  (oq_full),
    .empty (empty)
  );

endmodule

FILE: rtl/sbc_chk.sv
// Port-level checks for swept_box_collision, attached by bind.
// Depends on sbc_pkg.
module sbc_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              empty,
  input logic              pop,
  input sbc_pkg::sbc_out_t out_data
);

  // Reset drains the result queue
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // A waiting result stays until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty)
    else $error("result vanished without pop");

  // A miss carries the fixed miss pattern
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_data.hit |->
      out_data.hit_axis == sbc_pkg::AXIS_NONE && out_data.push_value == 32'sd0 &&
      out_data.hit_ratio == sbc_pkg::ONE_Q && out_data.time_left == '1 &&
      out_data.contact_x == 32'sd0 && out_data.contact_y == 32'sd0)
    else $error("miss result with stray fields");

  // A hit names an axis and a ratio within the frame
  a_hit: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_data.hit |->
      (out_data.hit_axis == sbc_pkg::AXIS_X || out_data.hit_axis == sbc_pkg::AXIS_Y) &&
      out_data.hit_ratio <= sbc_pkg::ONE_Q)
    else $error("hit result with bad axis or ratio");

endmodule

bind swept_box_collision sbc_chk u_chk (.*);
